// ----- rtl/core/smv_pkg.sv -----
// smv_pkg: shared types, field widths and helpers for the sample mean and variance block
// no dependencies; imported by smv_ctrl, smv_datapath and sample_mean_variance
`timescale 1ns / 1ps
`default_nettype none

package smv_pkg;

    // default widths of the accumulated sample and the sample counter
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF  = 16;

    // fixed field widths of the stream payloads
    localparam int SAMPLE_W   = 10;
    localparam int MEAN_W     = 10;
    localparam int VAR_W      = 18;
    localparam int SAMPLES_W  = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 48;

    // result field positions inside m_tdata
    localparam int MEAN_LSB    = 0;
    localparam int VAR_LSB     = MEAN_LSB + MEAN_W;
    localparam int SAMPLES_LSB = VAR_LSB + VAR_W;
    localparam int PAD_LSB     = SAMPLES_LSB + SAMPLES_W;

    // operation selected on the shared multiplier and divider
    typedef enum logic [2:0] {
        OP_N_SQ    = 3'd0,  // count times sum of squares
        OP_SUM_SUM = 3'd1,  // sum squared
        OP_N_N     = 3'd2,  // count squared
        OP_MEAN    = 3'd3,  // sum over count
        OP_VAR     = 3'd4   // spread over count squared
    } smv_op_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    accept;    // input beat taken this cycle
        logic    mul_load;  // load multiplier operands for op
        logic    mul_step;  // one shift-add step
        logic    div_load;  // load divider operands for op
        logic    div_step;  // one restoring step
        logic    out_load;  // move results into the output register
        smv_op_t op;
    } smv_cmd_t;

    // working width of the divider: full product width, never below the variance field
    function automatic int div_width(input int sample_bits, input int count_bits);
        int prod_w;
        prod_w = 2 * (sample_bits + count_bits);
        return (prod_w > VAR_W) ? prod_w : VAR_W;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/smv_ctrl.sv -----
// smv_ctrl: sequencing state machine for accumulation, multiply, divide and output
// depends on smv_pkg for the command struct, op codes and width helper
`timescale 1ns / 1ps
`default_nettype none

module smv_ctrl #(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 16
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    input  wire               s_tlast,
    output logic              s_tready,
    input  wire               m_tready,
    output logic              m_tvalid,
    output smv_pkg::smv_cmd_t cmd
);
    import smv_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
    localparam int DIV_W = div_width(SAMPLE_BITS, COUNT_BITS);
    localparam int CNT_W = $clog2(DIV_W);

    typedef enum logic [5:0] {
        ST_ACC   = 6'b000001,
        ST_MLOAD = 6'b000010,
        ST_MSTEP = 6'b000100,
        ST_DLOAD = 6'b001000,
        ST_DSTEP = 6'b010000,
        ST_HOLD  = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    smv_op_t         op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            beat;
    logic            mul_done, div_done;

    assign s_tready = (state_reg == ST_ACC);
    assign m_tvalid = m_tvalid_reg;
    assign beat     = s_tvalid && s_tready;
    assign mul_done = (cnt_reg == CNT_W'(SUM_W - 1));
    assign div_done = (cnt_reg == CNT_W'(DIV_W - 1));

    // next state and command decode
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.op       = op_reg;
        cmd.accept   = beat;
        case (state_reg)
            ST_ACC: begin
                if (beat && s_tlast) begin
                    op_next    = OP_N_SQ;
                    state_next = ST_MLOAD;
                end
            end
            ST_MLOAD: begin
                cmd.mul_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_MSTEP;
            end
            ST_MSTEP: begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (mul_done) begin
                    case (op_reg)
                        OP_N_SQ: begin
                            op_next    = OP_SUM_SUM;
                            state_next = ST_MLOAD;
                        end
                        OP_SUM_SUM: begin
                            op_next    = OP_N_N;
                            state_next = ST_MLOAD;
                        end
                        default: begin
                            op_next    = OP_MEAN;
                            state_next = ST_DLOAD;
                        end
                    endcase
                end
            end
            ST_DLOAD: begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DSTEP;
            end
            ST_DSTEP: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (div_done) begin
                    if (op_reg == OP_MEAN) begin
                        op_next    = OP_VAR;
                        state_next = ST_DLOAD;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                // results finished, wait until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    // output valid: set on load, cleared when the beat is taken
    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_ACC;
            op_reg       <= OP_N_SQ;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/smv_datapath.sv -----
// smv_datapath: accumulators, shift-add multiplier, restoring divider and output register
// depends on smv_pkg; driven by commands from smv_ctrl
`timescale 1ns / 1ps
`default_nettype none

module smv_datapath #(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 16
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  smv_pkg::smv_cmd_t                  cmd,
    input  wire  [smv_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire                                s_tlast,
    output logic [smv_pkg::M_TDATA_W-1:0]      m_tdata
);
    import smv_pkg::*;

    localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_W   = 2 * SAMPLE_BITS + COUNT_BITS;
    localparam int PROD_W = 2 * SUM_W;
    localparam int DIV_W  = div_width(SAMPLE_BITS, COUNT_BITS);

    // running accumulators
    logic [COUNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [SQ_W-1:0]          sq_reg, sq_next;
    // block snapshot taken on the last beat
    logic [COUNT_BITS-1:0]    n_reg;
    logic [SUM_W-1:0]         s_reg;
    logic [SQ_W-1:0]          q_reg;
    // multiplier
    logic [PROD_W-1:0]        mul_a_reg, mul_acc_reg, mul_acc_next;
    logic [SUM_W-1:0]         mul_b_reg;
    logic [PROD_W-1:0]        prod_reg, sqr_reg, nn_reg;
    // divider
    logic [DIV_W-1:0]         rem_reg, dvd_reg, dvs_reg;
    logic [DIV_W:0]           shifted, trial;
    logic                     fits;
    logic [DIV_W-1:0]         rem_next, quo_next;
    logic [PROD_W-1:0]        var_diff;
    logic [MEAN_W-1:0]        mean_res_reg, mean_out_reg;
    logic [VAR_W-1:0]         var_res_reg, var_out_reg;
    logic [SAMPLES_W-1:0]     samples_out_reg;
    // sample path
    logic [SAMPLE_BITS-1:0]   samp;
    logic [2*SAMPLE_BITS-1:0] samp_sq;
    logic [SUM_W-1:0]         sum_add;
    logic [SQ_W-1:0]          sq_add;

    assign samp    = SAMPLE_BITS'(s_tdata[SAMPLE_W-1:0]);
    assign samp_sq = samp * samp;

    // accumulate unless the counter is saturated
    always_comb begin
        if (&cnt_reg) begin
            cnt_next = cnt_reg;
            sum_add  = sum_reg;
            sq_add   = sq_reg;
        end else begin
            cnt_next = cnt_reg + 1'b1;
            sum_add  = sum_reg + SUM_W'(samp);
            sq_add   = sq_reg + SQ_W'(samp_sq);
        end
        sum_next = sum_add;
        sq_next  = sq_add;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
        end else if (cmd.accept) begin
            if (s_tlast) begin
                cnt_reg <= '0;
                sum_reg <= '0;
                sq_reg  <= '0;
            end else begin
                cnt_reg <= cnt_next;
                sum_reg <= sum_next;
                sq_reg  <= sq_next;
            end
        end
    end

    // snapshot of the closed block
    always_ff @(posedge aclk) begin
        if (cmd.accept && s_tlast) begin
            n_reg <= cnt_next;
            s_reg <= sum_next;
            q_reg <= sq_next;
        end
    end

    // shift-add multiplier, one multiplier bit per step
    assign mul_acc_next = mul_acc_reg + (mul_b_reg[0] ? mul_a_reg : '0);

    always_ff @(posedge aclk) begin
        if (cmd.mul_load) begin
            mul_acc_reg <= '0;
            case (cmd.op)
                OP_N_SQ: begin
                    mul_a_reg <= PROD_W'(q_reg);
                    mul_b_reg <= SUM_W'(n_reg);
                end
                OP_SUM_SUM: begin
                    mul_a_reg <= PROD_W'(s_reg);
                    mul_b_reg <= s_reg;
                end
                default: begin
                    mul_a_reg <= PROD_W'(n_reg);
                    mul_b_reg <= SUM_W'(n_reg);
                end
            endcase
        end else if (cmd.mul_step) begin
            mul_acc_reg <= mul_acc_next;
            mul_a_reg   <= {mul_a_reg[PROD_W-2:0], 1'b0};
            mul_b_reg   <= {1'b0, mul_b_reg[SUM_W-1:1]};
        end
    end

    // product registers follow the running sum of the selected op
    always_ff @(posedge aclk) begin
        if (cmd.mul_step) begin
            case (cmd.op)
                OP_N_SQ:    prod_reg <= mul_acc_next;
                OP_SUM_SUM: sqr_reg  <= mul_acc_next;
                OP_N_N:     nn_reg   <= mul_acc_next;
                default:    nn_reg   <= nn_reg;
            endcase
        end
    end

    // spread term, clamped at zero
    assign var_diff = (prod_reg >= sqr_reg) ? (prod_reg - sqr_reg) : '0;

    // restoring divider, one quotient bit per step
    assign shifted  = {rem_reg, dvd_reg[DIV_W-1]};
    assign trial    = shifted - {1'b0, dvs_reg};
    assign fits     = (shifted >= {1'b0, dvs_reg});
    assign rem_next = fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
    assign quo_next = {dvd_reg[DIV_W-2:0], fits};

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            rem_reg <= '0;
            if (cmd.op == OP_MEAN) begin
                dvd_reg <= DIV_W'(s_reg);
                dvs_reg <= DIV_W'(n_reg);
            end else begin
                dvd_reg <= DIV_W'(var_diff);
                dvs_reg <= DIV_W'(nn_reg);
            end
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            dvd_reg <= quo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_step) begin
            if (cmd.op == OP_MEAN) begin
                mean_res_reg <= quo_next[MEAN_W-1:0];
            end else begin
                var_res_reg  <= quo_next[VAR_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            mean_out_reg    <= mean_res_reg;
            var_out_reg     <= var_res_reg;
            samples_out_reg <= SAMPLES_W'(n_reg);
        end
    end

    assign m_tdata = {{(M_TDATA_W - PAD_LSB){1'b0}}, samples_out_reg, var_out_reg, mean_out_reg};

endmodule

`default_nettype wire

// ----- rtl/core/sample_mean_variance.sv -----
// sample_mean_variance: integer mean and population variance over blocks of samples
// depends on smv_pkg, smv_ctrl and smv_datapath
//
// Usage:
//   Input stream s_*: one sample per beat in s_tdata, s_tlast on the final sample of a
//   block. Sample count, sum and sum of squares are accumulated one beat per cycle while s_tready is high.
//   Output stream m_*: one beat per block carrying mean, variance and sample count.
// Block evaluation:
//   Non-final beats are taken back to back. After the final beat the input is held off
//   while three shift-add multiplies and two restoring divides run on shared units and
//   the output register loads, and for longer while an earlier result still waits.
//   m_tvalid rises and s_tready returns together once the output register has loaded.
// Counter saturation:
//   Once the count reaches its maximum further samples are dropped; the final beat
//   still closes the block.
// Reset and stalls:
//   aresetn clears the accumulators, the sequencer and m_tvalid. A finished result sits
//   in the output register until taken; the next block streams in meanwhile, and only
//   its own result waits for the register to free up.
`timescale 1ns / 1ps
`default_nettype none

module sample_mean_variance #(
    parameter int SAMPLE_BITS = smv_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = smv_pkg::COUNT_BITS_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    // s_tdata: [9:0] sample, [15:10] zero
    input  wire  [smv_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire                           s_tvalid,
    input  wire                           s_tlast,
    output logic                          s_tready,
    // m_tdata: [9:0] mean, [27:10] variance, [43:28] samples, [47:44] zero
    output logic [smv_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  wire                           m_tready
);
    import smv_pkg::*;

    smv_cmd_t cmd;

    // sequencer
    smv_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    // arithmetic
    smv_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tdata (m_tdata)
    );

    // a closing beat holds off input while the block is evaluated
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input accepted right after a closing beat");

    // every reported block has at least one sample
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[PAD_LSB-1:SAMPLES_LSB] != '0))
        else $error("result with zero sample count");

    // no result straight out of reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
